>>> hw/rtl/msq_pkg.sv
// Shared types and constants of the modem message sequencer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package msq_pkg;

	// Event codes carried by the mode field of an input item.
	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_ENQUEUE = 2'd1,
		MODE_OK      = 2'd2,
		MODE_ERR     = 2'd3
	} mode_e;

	// Command codes of a result item.
	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_SEND    = 3'd1,
		CMD_READ    = 3'd2,
		CMD_DELETE  = 3'd3,
		CMD_SENT_OK = 3'd4,
		CMD_FAILED  = 3'd5
	} cmd_e;

	// Line status codes.
	typedef enum logic [1:0] {
		LINE_IDLE   = 2'd0,
		LINE_BUSY   = 2'd1,
		LINE_HALTED = 2'd2
	} line_e;

	// Sequencer phase, one-hot.
	typedef enum logic [3:0] {
		PH_REST = 4'b0001,
		PH_SEND = 4'b0010,
		PH_READ = 4'b0100,
		PH_DEL  = 4'b1000
	} phase_e;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_IDLE_THRESHOLD     = 3'd0,
		REG_SEND_ATTEMPT_LIMIT = 3'd1,
		REG_HALT_FAIL_LIMIT    = 3'd2,
		REG_REST_SECONDS       = 3'd3,
		REG_SEND_TIMEOUT       = 3'd4,
		REG_READ_TIMEOUT       = 3'd5,
		REG_DELETE_TIMEOUT     = 3'd6
	} reg_idx_e;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned ID_W       = 16;

	localparam logic [7:0] RST_IDLE_THRESHOLD     = 8'd5;
	localparam logic [3:0] RST_SEND_ATTEMPT_LIMIT = 4'd2;
	localparam logic [3:0] RST_HALT_FAIL_LIMIT    = 4'd2;
	localparam logic [7:0] RST_REST_SECONDS       = 8'd5;
	localparam logic [7:0] RST_SEND_TIMEOUT       = 8'd10;
	localparam logic [7:0] RST_READ_TIMEOUT       = 8'd15;
	localparam logic [7:0] RST_DELETE_TIMEOUT     = 8'd5;

	localparam logic [7:0] SAT8_MAX = 8'hFF;
	localparam logic [3:0] SAT4_MAX = 4'hF;

	typedef struct packed {
		logic [7:0] idle_threshold;
		logic [3:0] send_attempt_limit;
		logic [3:0] halt_fail_limit;
		logic [7:0] rest_seconds;
		logic [7:0] send_timeout;
		logic [7:0] read_timeout;
		logic [7:0] delete_timeout;
	} cfg_t;

	// Queue operation requested by the controller.
	typedef struct packed {
		logic            push;
		logic            pop;
		logic [ID_W-1:0] push_id;
	} q_op_t;

	// Queue status seen by the controller.
	typedef struct packed {
		logic            nonempty;
		logic            full;
		logic            busy_next;
		logic [ID_W-1:0] front_id;
	} q_stat_t;

	typedef struct packed {
		cmd_e            command;
		logic [ID_W-1:0] command_id;
		logic [7:0]      delete_slot;
		logic [7:0]      received_count;
		line_e           line_status;
		logic            dropped;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/modem_message_sequencer_unit.sv
// Top level of the modem message sequencer: input stage, result register and
// configuration registers. Depends on msq_pkg, msq_send_queue and msq_ctrl.
//
// Channel   Direction  Handshake              Carries
// in        to block   in_valid / in_ready    mode, message_id, list_count
// out       from block out_valid / out_ready  command, command_id, delete_slot,
//                                             received_count, line_status, dropped
// cfg       to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every input item gives exactly one result item. An accepted item is held in the
// input stage and is then worked into the result register, which drives the
// output; one item can be taken every cycle while out_ready is held high.
// The front of the send queue is prefetched from the queue memory's registered
// read port, which is what lets a pop and its id fit in the same cycle.
// When the result register holds an untaken item, the input stage holds too and
// in_ready falls only while both hold an item and the result is not taken. Reset
// clears all control state and loads the register defaults; the queue memory
// needs no clearing pass.
`default_nettype none

module modem_message_sequencer_unit #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] message_id,
	input  wire logic [7:0]  list_count,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       command,
	output logic [15:0]      command_id,
	output logic [7:0]       delete_slot,
	output logic [7:0]       received_count,
	output logic [1:0]       line_status,
	output logic             dropped,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	// Configuration registers. Writes are always accepted.
	msq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_threshold     <= msq_pkg::RST_IDLE_THRESHOLD;
			cfg_q.send_attempt_limit <= msq_pkg::RST_SEND_ATTEMPT_LIMIT;
			cfg_q.halt_fail_limit    <= msq_pkg::RST_HALT_FAIL_LIMIT;
			cfg_q.rest_seconds       <= msq_pkg::RST_REST_SECONDS;
			cfg_q.send_timeout       <= msq_pkg::RST_SEND_TIMEOUT;
			cfg_q.read_timeout       <= msq_pkg::RST_READ_TIMEOUT;
			cfg_q.delete_timeout     <= msq_pkg::RST_DELETE_TIMEOUT;
		end else if (cfg_valid) begin
			unique case (msq_pkg::reg_idx_e'(cfg_index))
				msq_pkg::REG_IDLE_THRESHOLD:     cfg_q.idle_threshold     <= cfg_data;
				msq_pkg::REG_SEND_ATTEMPT_LIMIT: cfg_q.send_attempt_limit <= cfg_data[3:0];
				msq_pkg::REG_HALT_FAIL_LIMIT:    cfg_q.halt_fail_limit    <= cfg_data[3:0];
				msq_pkg::REG_REST_SECONDS:       cfg_q.rest_seconds       <= cfg_data;
				msq_pkg::REG_SEND_TIMEOUT:       cfg_q.send_timeout       <= cfg_data;
				msq_pkg::REG_READ_TIMEOUT:       cfg_q.read_timeout       <= cfg_data;
				msq_pkg::REG_DELETE_TIMEOUT:     cfg_q.delete_timeout     <= cfg_data;
				default: begin
					// Indexes past the register list are ignored.
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// Input stage. The item in it is worked off in the cycle the result
	// register can take its result.
	logic                     valid_s1;
	logic [1:0]               mode_s1;
	logic [15:0]              message_id_s1;
	logic [7:0]               list_count_s1;
	logic                     out_valid_q;
	logic                     proc;
	msq_pkg::result_t         res_d;
	msq_pkg::result_t         result_q;
	msq_pkg::q_op_t           qop;
	msq_pkg::q_stat_t         qstat;

	assign proc     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1       <= mode;
			message_id_s1 <= message_id;
			list_count_s1 <= list_count;
		end
	end

	msq_send_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (qop),
		.idle_threshold (cfg_q.idle_threshold),
		.stat           (qstat)
	);

	msq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.proc       (proc),
		.mode       (mode_s1),
		.message_id (message_id_s1),
		.list_count (list_count_s1),
		.cfg        (cfg_q),
		.qstat      (qstat),
		.qop        (qop),
		.res        (res_d)
	);

	// Result register: loads when an item is worked off, empties when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			result_q <= res_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign command        = result_q.command;
	assign command_id     = result_q.command_id;
	assign delete_slot    = result_q.delete_slot;
	assign received_count = result_q.received_count;
	assign line_status    = result_q.line_status;
	assign dropped        = result_q.dropped;

endmodule

`default_nettype wire

>>> hw/rtl/msq_send_queue.sv
// Ring queue of outgoing message ids with a first-word-fall-through front.
// Depends on msq_pkg for the queue operation and status structs.
`default_nettype none

module msq_send_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire msq_pkg::q_op_t  op,
	input  wire logic [7:0]      idle_threshold,
	output msq_pkg::q_stat_t     stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned TW = (CW > 8) ? CW : 8;

	logic [msq_pkg::ID_W-1:0] mem [DEPTH];
	logic [msq_pkg::ID_W-1:0] rd_data_q;
	logic [msq_pkg::ID_W-1:0] byp_id_q;
	logic                     byp_use_q;

	logic [AW-1:0] head_q, tail_q, head_d, tail_d;
	logic [CW-1:0] count_q, count_d;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
		return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	always_comb begin
		head_d  = op.pop  ? wrap_inc(head_q) : head_q;
		tail_d  = op.push ? wrap_inc(tail_q) : tail_q;
		count_d = count_q;
		if (op.push) begin
			count_d = count_q + 1'b1;
		end else if (op.pop) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			byp_use_q <= 1'b0;
		end else begin
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			// A push into an empty queue lands on the head entry, which the
			// read port sampled before the write; hold the id aside until the port has it.
			byp_use_q <= op.push && (count_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			byp_id_q     <= op.push_id;
			mem[tail_q]  <= op.push_id;
		end
		rd_data_q <= mem[head_d];
	end

	assign stat.nonempty  = (count_q != '0);
	assign stat.full      = (count_q == CW'(DEPTH));
	assign stat.busy_next = (TW'(count_d) >= TW'(idle_threshold));
	assign stat.front_id  = byp_use_q ? byp_id_q : rd_data_q;

endmodule

`default_nettype wire

>>> hw/rtl/msq_ctrl.sv
// Phase, timer and counter logic of the sequencer, one event per cycle while proc is high.
// Depends on msq_pkg for codes, the configuration and the queue structs.
`default_nettype none

module msq_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      proc,
	input  wire logic [1:0]                mode,
	input  wire logic [msq_pkg::ID_W-1:0]  message_id,
	input  wire logic [7:0]                list_count,
	input  wire msq_pkg::cfg_t             cfg,
	input  wire msq_pkg::q_stat_t          qstat,
	output msq_pkg::q_op_t                 qop,
	output msq_pkg::result_t               res
);

	msq_pkg::phase_e           phase_q, phase_d;
	logic [7:0]                elapsed_q, elapsed_d, elapsed_inc;
	logic [msq_pkg::ID_W-1:0]  current_id_q, current_id_d;
	logic [3:0]                attempts_q, attempts_d, attempts_inc;
	logic [3:0]                failed_run_q, failed_run_d;
	logic [7:0]                list_total_q, list_total_d;
	logic [7:0]                delete_pos_q, delete_pos_d, delete_pos_inc;

	assign elapsed_inc    = (elapsed_q == msq_pkg::SAT8_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign attempts_inc   = (attempts_q == msq_pkg::SAT4_MAX) ? attempts_q : attempts_q + 1'b1;
	assign delete_pos_inc = (delete_pos_q == msq_pkg::SAT8_MAX) ? delete_pos_q
		: delete_pos_q + 1'b1;

	always_comb begin
		phase_d      = phase_q;
		elapsed_d    = elapsed_q;
		current_id_d = current_id_q;
		attempts_d   = attempts_q;
		failed_run_d = failed_run_q;
		list_total_d = list_total_q;
		delete_pos_d = delete_pos_q;

		qop.push    = 1'b0;
		qop.pop     = 1'b0;
		qop.push_id = message_id;

		res.command        = msq_pkg::CMD_NONE;
		res.command_id     = '0;
		res.delete_slot    = '0;
		res.received_count = '0;
		res.dropped        = 1'b0;

		if (proc) begin
			unique case (msq_pkg::mode_e'(mode))
				msq_pkg::MODE_TICK: begin
					elapsed_d = elapsed_inc;
					unique case (phase_q)
						msq_pkg::PH_REST: begin
							if (qstat.nonempty) begin
								qop.pop        = 1'b1;
								current_id_d   = qstat.front_id;
								attempts_d     = attempts_inc;
								phase_d        = msq_pkg::PH_SEND;
								elapsed_d      = '0;
								res.command    = msq_pkg::CMD_SEND;
								res.command_id = qstat.front_id;
							end else if (elapsed_inc >= cfg.rest_seconds) begin
								phase_d     = msq_pkg::PH_READ;
								elapsed_d   = '0;
								res.command = msq_pkg::CMD_READ;
							end
						end
						msq_pkg::PH_SEND: begin
							if (elapsed_inc >= cfg.send_timeout) begin
								attempts_d     = attempts_inc;
								elapsed_d      = '0;
								res.command    = msq_pkg::CMD_SEND;
								res.command_id = current_id_q;
							end
						end
						msq_pkg::PH_READ: begin
							if (elapsed_inc >= cfg.read_timeout) begin
								phase_d   = msq_pkg::PH_REST;
								elapsed_d = '0;
							end
						end
						msq_pkg::PH_DEL: begin
							if (elapsed_inc >= cfg.delete_timeout) begin
								phase_d   = msq_pkg::PH_REST;
								elapsed_d = '0;
							end
						end
						default: begin
							phase_d = msq_pkg::PH_REST;
						end
					endcase
				end
				msq_pkg::MODE_ENQUEUE: begin
					if (qstat.full) begin
						res.dropped = 1'b1;
					end else begin
						qop.push = 1'b1;
					end
				end
				msq_pkg::MODE_OK: begin
					unique case (phase_q)
						msq_pkg::PH_SEND: begin
							res.command    = msq_pkg::CMD_SENT_OK;
							res.command_id = current_id_q;
							attempts_d     = '0;
							failed_run_d   = '0;
							phase_d        = msq_pkg::PH_REST;
							elapsed_d      = '0;
						end
						msq_pkg::PH_READ: begin
							list_total_d       = list_count;
							res.received_count = list_count;
							elapsed_d          = '0;
							if (list_count != '0) begin
								delete_pos_d = '0;
								phase_d      = msq_pkg::PH_DEL;
								res.command  = msq_pkg::CMD_DELETE;
							end else begin
								phase_d = msq_pkg::PH_REST;
							end
						end
						msq_pkg::PH_DEL: begin
							delete_pos_d = delete_pos_inc;
							elapsed_d    = '0;
							if (delete_pos_inc < list_total_q) begin
								res.command     = msq_pkg::CMD_DELETE;
								res.delete_slot = delete_pos_inc;
							end else begin
								phase_d = msq_pkg::PH_REST;
							end
						end
						default: begin
						end
					endcase
				end
				msq_pkg::MODE_ERR: begin
					unique case (phase_q)
						msq_pkg::PH_SEND: begin
							elapsed_d      = '0;
							res.command_id = current_id_q;
							if (attempts_q >= cfg.send_attempt_limit) begin
								res.command  = msq_pkg::CMD_FAILED;
								attempts_d   = '0;
								failed_run_d = (failed_run_q == msq_pkg::SAT4_MAX)
									? failed_run_q : failed_run_q + 1'b1;
								phase_d      = msq_pkg::PH_REST;
							end else begin
								attempts_d  = attempts_inc;
								res.command = msq_pkg::CMD_SEND;
							end
						end
						msq_pkg::PH_READ: begin
							phase_d   = msq_pkg::PH_REST;
							elapsed_d = '0;
						end
						msq_pkg::PH_DEL: begin
							elapsed_d       = '0;
							res.command     = msq_pkg::CMD_DELETE;
							res.delete_slot = delete_pos_q;
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end

		// Status reflects the state after this event.
		if (failed_run_d >= cfg.halt_fail_limit) begin
			res.line_status = msq_pkg::LINE_HALTED;
		end else if (qstat.busy_next) begin
			res.line_status = msq_pkg::LINE_BUSY;
		end else begin
			res.line_status = msq_pkg::LINE_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= msq_pkg::PH_REST;
			elapsed_q    <= '0;
			current_id_q <= '0;
			attempts_q   <= '0;
			failed_run_q <= '0;
			list_total_q <= '0;
			delete_pos_q <= '0;
		end else begin
			phase_q      <= phase_d;
			elapsed_q    <= elapsed_d;
			current_id_q <= current_id_d;
			attempts_q   <= attempts_d;
			failed_run_q <= failed_run_d;
			list_total_q <= list_total_d;
			delete_pos_q <= delete_pos_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/msq_checker.sv
// Port-level checks of the modem message sequencer and their bind.
// Depends on msq_pkg and on the ports of modem_message_sequencer_unit.
`default_nettype none

module msq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  command,
	input wire logic [15:0] command_id,
	input wire logic [7:0]  delete_slot,
	input wire logic [7:0]  received_count,
	input wire logic [1:0]  line_status,
	input wire logic        dropped
);

	// A stalled result item holds its command, command id and line status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command)
			&& $stable(command_id) && $stable(line_status))
		else $error("stalled result item changed");

	// An id travels only with send and report commands.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (command == msq_pkg::CMD_NONE || command == msq_pkg::CMD_READ
			|| command == msq_pkg::CMD_DELETE) |-> command_id == '0)
		else $error("command id on a command that carries none");

	// A dropped enqueue issues nothing to the modem.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> command == msq_pkg::CMD_NONE)
		else $error("dropped enqueue produced a command");

	// A nonzero received count only comes with the first delete of a list.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && received_count != '0 |->
			command == msq_pkg::CMD_DELETE && delete_slot == '0)
		else $error("received count without first delete");

	// Status and command codes stay within their defined sets.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_status != 2'd3 && command <= msq_pkg::CMD_FAILED)
		else $error("undefined command or status code");

endmodule

bind modem_message_sequencer_unit msq_checker u_msq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.command        (command),
	.command_id     (command_id),
	.delete_slot    (delete_slot),
	.received_count (received_count),
	.line_status    (line_status),
	.dropped        (dropped)
);

`default_nettype wire
